// File: rtl/id3p_pkg.sv
// Shared types and constants for the ID3v2 tag stream parser.
package id3p_pkg;

  // Parser phases
  typedef enum logic [2:0] {
    PH_HEADER   = 3'd0,
    PH_SCAN     = 3'd1,
    PH_LENGTH   = 3'd2,
    PH_ENCODING = 3'd3,
    PH_TEXT     = 3'd4,
    PH_DONE     = 3'd5
  } phase_t;

  // Event codes
  localparam logic [2:0] EV_NONE       = 3'd0;
  localparam logic [2:0] EV_HDR_OK     = 3'd1;
  localparam logic [2:0] EV_HDR_ERR    = 3'd2;
  localparam logic [2:0] EV_FRAME_TAG  = 3'd3;
  localparam logic [2:0] EV_FRAME_LEN  = 3'd4;
  localparam logic [2:0] EV_TEXT_BYTE  = 3'd5;
  localparam logic [2:0] EV_REGION_END = 3'd6;
  localparam logic [2:0] EV_TRUNCATED  = 3'd7;

  // Header error codes
  localparam logic [2:0] ERR_NONE     = 3'd0;
  localparam logic [2:0] ERR_MAGIC    = 3'd1;
  localparam logic [2:0] ERR_VERSION  = 3'd2;
  localparam logic [2:0] ERR_REVISION = 3'd3;
  localparam logic [2:0] ERR_SIZE     = 3'd4;

  // Header byte positions
  localparam logic [3:0] POS_MAGIC0   = 4'd0;
  localparam logic [3:0] POS_MAGIC1   = 4'd1;
  localparam logic [3:0] POS_MAGIC2   = 4'd2;
  localparam logic [3:0] POS_VERSION  = 4'd3;
  localparam logic [3:0] POS_REVISION = 4'd4;
  localparam logic [3:0] POS_FLAGS    = 4'd5;
  localparam logic [3:0] POS_SIZE0    = 4'd6;
  localparam logic [3:0] POS_SIZE3    = 4'd9;
  localparam logic [3:0] LEN_BYTES    = 4'd3;

  // Character constants
  localparam logic [7:0] CH_I      = 8'h49;
  localparam logic [7:0] CH_D      = 8'h44;
  localparam logic [7:0] CH_3      = 8'h33;
  localparam logic [7:0] CH_T      = 8'h54;
  localparam logic [7:0] CH_LO     = 8'h30;
  localparam logic [7:0] CH_HI     = 8'h5A;
  localparam logic [7:0] BYTE_FF   = 8'hFF;
  localparam logic [1:0] MATCH_ALL = 2'd3;

  // Parser state
  typedef struct packed {
    phase_t      phase;
    logic [3:0]  byte_position;
    logic [7:0]  saved_version;
    logic [7:0]  saved_revision;
    logic [7:0]  saved_flags;
    logic [27:0] region_left;
    logic [1:0]  match_count;
    logic [23:0] tag_buffer;
    logic [23:0] frame_length;
    logic [23:0] text_left;
    logic [7:0]  saved_encoding;
  } state_t;

  localparam state_t STATE_RESET = '{phase: PH_HEADER, default: '0};

  // One result item
  typedef struct packed {
    logic [2:0]  event_res;
    logic [2:0]  error_code;
    logic [27:0] length_value;
    logic [23:0] tag_chars;
    logic [7:0]  text_encoding;
    logic [7:0]  text_value;
    logic [7:0]  major_version;
    logic [7:0]  minor_revision;
    logic [7:0]  header_flags;
  } result_t;

endpackage

// File: rtl/id3p_step.sv
// Next-state and result logic for one byte of the parser.
module id3p_step (
  input  logic [7:0]      data_byte,
  input  logic            file_start,
  input  id3p_pkg::state_t cur,
  output id3p_pkg::state_t nxt,
  output id3p_pkg::result_t res
);

  id3p_pkg::state_t s;
  logic [2:0]  err;
  logic [1:0]  cnt;
  logic [23:0] tb;
  logic [23:0] fl;
  logic [3:0]  bp;
  logic [23:0] tl;
  logic        in_range;

  assign in_range = (data_byte >= id3p_pkg::CH_LO) && (data_byte <= id3p_pkg::CH_HI);

  always_comb begin
    // restart on a new file
    s = cur;
    if (file_start) begin
      s = id3p_pkg::STATE_RESET;
    end
    nxt = s;
    res = '0;
    err = id3p_pkg::ERR_NONE;
    cnt = '0;
    tb  = {s.tag_buffer[15:0], data_byte};
    fl  = {s.frame_length[15:0], data_byte};
    bp  = s.byte_position + 4'd1;
    tl  = s.text_left - 24'd1;

    unique case (s.phase) inside
      id3p_pkg::PH_HEADER: begin
        // check header bytes
        case (s.byte_position)
          id3p_pkg::POS_MAGIC0: if (data_byte != id3p_pkg::CH_I) err = id3p_pkg::ERR_MAGIC;
          id3p_pkg::POS_MAGIC1: if (data_byte != id3p_pkg::CH_D) err = id3p_pkg::ERR_MAGIC;
          id3p_pkg::POS_MAGIC2: if (data_byte != id3p_pkg::CH_3) err = id3p_pkg::ERR_MAGIC;
          id3p_pkg::POS_VERSION: begin
            if (data_byte == id3p_pkg::BYTE_FF) err = id3p_pkg::ERR_VERSION;
            else nxt.saved_version = data_byte;
          end
          id3p_pkg::POS_REVISION: begin
            if (data_byte == id3p_pkg::BYTE_FF) err = id3p_pkg::ERR_REVISION;
            else nxt.saved_revision = data_byte;
          end
          id3p_pkg::POS_FLAGS: nxt.saved_flags = data_byte;
          default: begin
            if (data_byte[7]) err = id3p_pkg::ERR_SIZE;
            else nxt.region_left = {s.region_left[20:0], data_byte[6:0]};
          end
        endcase
        if (err != id3p_pkg::ERR_NONE) begin
          res.event_res  = id3p_pkg::EV_HDR_ERR;
          res.error_code = err;
          nxt.phase      = id3p_pkg::PH_DONE;
        end else if (s.byte_position >= id3p_pkg::POS_SIZE3) begin
          res.event_res      = id3p_pkg::EV_HDR_OK;
          res.length_value   = nxt.region_left;
          res.major_version  = nxt.saved_version;
          res.minor_revision = nxt.saved_revision;
          res.header_flags   = nxt.saved_flags;
          nxt.phase          = id3p_pkg::PH_SCAN;
          nxt.match_count    = '0;
          nxt.byte_position  = '0;
        end else begin
          nxt.byte_position = bp;
        end
      end

      id3p_pkg::PH_SCAN, id3p_pkg::PH_LENGTH, id3p_pkg::PH_ENCODING,
      id3p_pkg::PH_TEXT: begin
        if (s.region_left == '0) begin
          // region exhausted
          res.event_res = (s.phase == id3p_pkg::PH_SCAN) ? id3p_pkg::EV_REGION_END
                                                         : id3p_pkg::EV_TRUNCATED;
          nxt.phase = id3p_pkg::PH_DONE;
        end else begin
          nxt.region_left = s.region_left - 28'd1;
          unique case (s.phase)
            id3p_pkg::PH_SCAN: begin
              // advance the tag match
              nxt.tag_buffer = tb;
              if ((data_byte == id3p_pkg::CH_T && s.match_count != id3p_pkg::MATCH_ALL) ||
                  ((s.match_count == 2'd1 || s.match_count == 2'd2) && in_range)) begin
                cnt = s.match_count + 2'd1;
              end
              if (cnt == id3p_pkg::MATCH_ALL) begin
                res.event_res     = id3p_pkg::EV_FRAME_TAG;
                res.tag_chars     = tb;
                nxt.match_count   = '0;
                nxt.phase         = id3p_pkg::PH_LENGTH;
                nxt.byte_position = '0;
                nxt.frame_length  = '0;
              end else begin
                nxt.match_count = cnt;
              end
            end
            id3p_pkg::PH_LENGTH: begin
              // collect the big-endian length
              nxt.frame_length = fl;
              if (bp >= id3p_pkg::LEN_BYTES) begin
                res.event_res     = id3p_pkg::EV_FRAME_LEN;
                res.length_value  = {4'd0, fl};
                res.tag_chars     = s.tag_buffer;
                nxt.byte_position = '0;
                nxt.phase         = id3p_pkg::PH_ENCODING;
              end else begin
                nxt.byte_position = bp;
              end
            end
            id3p_pkg::PH_ENCODING: begin
              nxt.saved_encoding = data_byte;
              nxt.text_left      = s.frame_length;
              nxt.phase = (s.frame_length != '0) ? id3p_pkg::PH_TEXT : id3p_pkg::PH_SCAN;
            end
            id3p_pkg::PH_TEXT: begin
              res.event_res     = id3p_pkg::EV_TEXT_BYTE;
              res.tag_chars     = s.tag_buffer;
              res.text_encoding = s.saved_encoding;
              res.text_value    = data_byte;
              nxt.text_left     = tl;
              if (tl == '0) nxt.phase = id3p_pkg::PH_SCAN;
            end
            default: ;
          endcase
        end
      end

      default: nxt.phase = id3p_pkg::PH_DONE;
    endcase
  end

endmodule

// File: rtl/id3v2_tag_stream_parser.sv
// Top level of the ID3v2 tag stream parser: input stage, state and result register.
// Each byte is registered in the input stage, and its result in the result register.
// Throughput: one byte per clock; the state update of one byte feeds the next.
// Stalls on the result side hold the input stage, which frees as results drain.
// Reset (rst_n low, synchronous) empties both stages and puts the parser
// back at header byte zero.
module id3v2_tag_stream_parser (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_file_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_event_res,
  output logic [2:0]  out_error_code,
  output logic [27:0] out_length_value,
  output logic [23:0] out_tag_chars,
  output logic [7:0]  out_text_encoding,
  output logic [7:0]  out_text_value,
  output logic [7:0]  out_major_version,
  output logic [7:0]  out_minor_revision,
  output logic [7:0]  out_header_flags
);

  logic               s1_valid_r;
  logic [7:0]         byte_r;
  logic               start_r;
  logic               out_valid_r;
  logic               advance;
  id3p_pkg::state_t   state_r;
  id3p_pkg::state_t   state_nxt;
  id3p_pkg::result_t  res_nxt;
  id3p_pkg::result_t  res_r;

  // move the input stage on when the result register is free
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r  <= in_data_byte;
      start_r <= in_file_start;
    end
  end

  id3p_step u_step (
    .data_byte  (byte_r),
    .file_start (start_r),
    .cur        (state_r),
    .nxt        (state_nxt),
    .res        (res_nxt)
  );

  // parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= id3p_pkg::STATE_RESET;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_event_res      = res_r.event_res;
  assign out_error_code     = res_r.error_code;
  assign out_length_value   = res_r.length_value;
  assign out_tag_chars      = res_r.tag_chars;
  assign out_text_encoding  = res_r.text_encoding;
  assign out_text_value     = res_r.text_value;
  assign out_major_version  = res_r.major_version;
  assign out_minor_revision = res_r.minor_revision;
  assign out_header_flags   = res_r.header_flags;

endmodule

// File: rtl/id3p_checker.sv
// Port-level assertions for the ID3v2 tag stream parser, bound to the top level.
module id3p_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_event_res,
  input logic [2:0]  out_error_code,
  input logic [7:0]  out_text_encoding,
  input logic [7:0]  out_text_value,
  input logic [7:0]  out_major_version,
  input logic [7:0]  out_minor_revision,
  input logic [7:0]  out_header_flags
);

  // a stalled result holds its event
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_res))
    else $error("result changed while stalled");

  // error code only on a header error
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res != id3p_pkg::EV_HDR_ERR |-> out_error_code == id3p_pkg::ERR_NONE)
    else $error("error code outside header error");

  // header bytes only on header ok
  a_hdr_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res != id3p_pkg::EV_HDR_OK |->
      out_major_version == 8'd0 && out_minor_revision == 8'd0 && out_header_flags == 8'd0)
    else $error("header fields outside header ok");

  // text fields only on a text byte
  a_text_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_event_res != id3p_pkg::EV_TEXT_BYTE |->
      out_text_value == 8'd0 && out_text_encoding == 8'd0)
    else $error("text fields outside text byte");

  // reset empties the result register
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind id3v2_tag_stream_parser id3p_checker u_id3p_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_event_res      (out_event_res),
  .out_error_code     (out_error_code),
  .out_text_encoding  (out_text_encoding),
  .out_text_value     (out_text_value),
  .out_major_version  (out_major_version),
  .out_minor_revision (out_minor_revision),
  .out_header_flags   (out_header_flags)
);
